/* hw/rtl/pmmu_pkg.sv */
package pmmu_pkg;

  localparam int unsigned MAP_ENTRIES_DEF = 32768;
  localparam int unsigned ADDR_W          = 19;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned CTX_W           = 7;
  localparam int unsigned PAGE_W          = 6;
  localparam int unsigned OFFSET_W        = 13;
  localparam int unsigned MAP_IDX_W       = CTX_W + 2 + PAGE_W;
  localparam int unsigned ENTRY_W         = DATA_W + 1;
  localparam int unsigned ENTRY_VALID_BIT = DATA_W;
  localparam int unsigned ENTRY_BERR_BIT  = 7;
  localparam int unsigned ENTRY_WP_BIT    = 6;
  localparam int unsigned LATCH_EN_BIT    = 7;

  typedef enum logic [STATUS_W-1:0] {
    STAT_RAM          = 3'd0,
    STAT_MAP_WRITTEN  = 3'd1,
    STAT_READ_OFF     = 3'd2,
    STAT_INVALID      = 3'd3,
    STAT_BUS_ERROR    = 3'd4,
    STAT_WRITE_FAULT  = 3'd5
  } pmmu_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } pmmu_state_e;

  typedef struct packed {
    pmmu_status_e        status;
    logic [ADDR_W-1:0]   phys;
    logic                berr;
  } pmmu_result_t;

endpackage

/* hw/rtl/pmmu_if.sv */
interface pmmu_req_if;
  import pmmu_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;
  logic                write;
  logic                supervisor;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output address, output write, output supervisor,
                  output write_data, input ready);
  modport sink   (input valid, input address, input write, input supervisor,
                  input write_data, output ready);
endinterface

interface pmmu_rsp_if;
  import pmmu_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   physical_address;
  logic                bus_error;

  modport source (output valid, output status, output physical_address,
                  output bus_error, input ready);
  modport sink   (input valid, input status, input physical_address,
                  input bus_error, output ready);
endinterface

interface pmmu_cfg_if;
  import pmmu_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   control_latch;

  modport source (output valid, output control_latch, input ready);
  modport sink   (input valid, input control_latch, output ready);
endinterface

/* hw/rtl/pmmu_ram.sv */
module pmmu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* hw/rtl/pmmu_decode.sv */
module pmmu_decode (
  input  logic [pmmu_pkg::ENTRY_W-1:0]  entry_i,
  input  logic                          write_i,
  input  logic [pmmu_pkg::OFFSET_W-1:0] offset_i,
  output pmmu_pkg::pmmu_result_t        result_o
);
  import pmmu_pkg::*;

  always_comb begin
    result_o.status = STAT_RAM;
    result_o.phys   = '0;
    result_o.berr   = 1'b0;
    if (!entry_i[ENTRY_VALID_BIT]) begin
      result_o.status = STAT_INVALID;
    end else if (entry_i[ENTRY_BERR_BIT]) begin
      result_o.status = STAT_BUS_ERROR;
      result_o.berr   = 1'b1;
    end else if (entry_i[ENTRY_WP_BIT] && write_i) begin
      result_o.status = STAT_WRITE_FAULT;
    end else begin
      result_o.phys = {entry_i[PAGE_W-1:0], offset_i};
    end
  end

endmodule

/* hw/rtl/paged_mmu_translate.sv */
// Page-map MMU for a 512 KiB SRAM card.
// req_i carries one bus access (address, write, supervisor, write_data);
// rsp_o returns one result per access (status, physical_address, bus_error).
// cfg_i writes control_latch: bit 7 enables mapping, bits 6..0 the context.
// cfg_i is always ready; write it only while no access is in flight.
// Map entries and their valid flags share one single-port RAM word.
// Mapping off: the result is registered in the cycle after the transfer.
// Mapping on: the RAM registers the entry, then decode loads the result.
// One access per cycle with mapping off while rsp_o does not stall; with
// mapping on, none in the lookup state (single RAM port, control sequence).
// A new access is taken while the previous result is being transferred.
// Reset: control_latch clears, then a clearing pass writes every map word
// invalid, one per cycle, all MAP_ENTRIES words (32768 by default); req_i is
// not ready during the pass.
// When rsp_o stalls, the result holds and req_i stays not ready.
module paged_mmu_translate #(
  parameter int unsigned MAP_ENTRIES = pmmu_pkg::MAP_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmmu_req_if.sink   req_i,
  pmmu_cfg_if.sink   cfg_i,
  pmmu_rsp_if.source rsp_o
);
  import pmmu_pkg::*;

  localparam int unsigned IdxW = $clog2(MAP_ENTRIES);

  pmmu_state_e             state_q, state_d;
  logic [DATA_W-1:0]       latch_q, latch_d;
  logic [IdxW-1:0]         clr_cnt_q, clr_cnt_d;
  logic                    wr_q, wr_d;
  logic [OFFSET_W-1:0]     offset_q, offset_d;
  logic                    rsp_valid_q, rsp_valid_d;
  pmmu_result_t            rsp_q, rsp_d;

  logic                    req_fire, rsp_fire, map_en, clear_done;
  logic                    req_ready, ram_we, ram_re, load_off, load_lookup;
  logic [MAP_IDX_W-1:0]    idx_full;
  logic [IdxW-1:0]         ram_addr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  pmmu_result_t            dec_result;

  assign map_en     = latch_q[LATCH_EN_BIT];
  assign req_fire   = req_i.valid && req_ready;
  assign rsp_fire   = rsp_valid_q && rsp_o.ready;
  assign clear_done = clr_cnt_q == IdxW'(MAP_ENTRIES - 1);
  assign idx_full   = {latch_q[CTX_W-1:0], req_i.supervisor, 1'b0,
                       req_i.address[ADDR_W-1 -: PAGE_W]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clear_done) state_d = S_IDLE;
      S_IDLE:   if (req_fire && map_en) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_off    = 1'b0;
    load_lookup = 1'b0;
    ram_addr    = IdxW'(idx_full);
    ram_wdata   = {1'b1, req_i.write_data};
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        req_ready = !rsp_valid_q || rsp_o.ready;
        if (req_fire) begin
          ram_we   = !map_en && req_i.write;
          ram_re   = map_en;
          load_off = !map_en;
        end
      end
      S_LOOKUP: load_lookup = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    latch_d     = latch_q;
    clr_cnt_d   = clr_cnt_q;
    wr_d        = wr_q;
    offset_d    = offset_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (cfg_i.valid) latch_d = cfg_i.control_latch;
    if (state_q == S_CLEAR) clr_cnt_d = clr_cnt_q + 1'b1;
    if (req_fire) begin
      wr_d     = req_i.write;
      offset_d = req_i.address[OFFSET_W-1:0];
    end
    if (rsp_fire) rsp_valid_d = 1'b0;
    if (load_off) begin
      rsp_valid_d  = 1'b1;
      rsp_d.status = req_i.write ? STAT_MAP_WRITTEN : STAT_READ_OFF;
      rsp_d.phys   = '0;
      rsp_d.berr   = 1'b0;
    end
    if (load_lookup) begin
      rsp_valid_d = 1'b1;
      rsp_d       = dec_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      latch_q     <= '0;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      latch_q     <= latch_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    offset_q <= offset_d;
    rsp_q    <= rsp_d;
  end

  pmmu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  pmmu_decode u_decode (
    .entry_i  (ram_rdata),
    .write_i  (wr_q),
    .offset_i (offset_q),
    .result_o (dec_result)
  );

  assign req_i.ready            = req_ready;
  assign cfg_i.ready            = 1'b1;
  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_q.status;
  assign rsp_o.physical_address = rsp_q.phys;
  assign rsp_o.bus_error        = rsp_q.berr;

endmodule

/* hw/rtl/pmmu_checker.sv */
module pmmu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [pmmu_pkg::STATUS_W-1:0] status_i,
  input logic [pmmu_pkg::ADDR_W-1:0]   phys_i,
  input logic                          bus_error_i
);
  import pmmu_pkg::*;

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(phys_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> !rsp_valid_i || rsp_ready_i)
    else $error("access taken while result slot is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> bus_error_i == (status_i == STAT_BUS_ERROR))
    else $error("bus_error disagrees with status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != STAT_RAM |-> phys_i == '0)
    else $error("physical address set on a non-ram result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_fire) || $past(req_fire, 2))
    else $error("result without a recent access");

endmodule

bind paged_mmu_translate pmmu_checker u_pmmu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .phys_i      (rsp_o.physical_address),
  .bus_error_i (rsp_o.bus_error)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

import pmmu_pkg::*;

class mmu_scoreboard;
  logic [DATA_W-1:0] latch;
  logic [DATA_W-1:0] entry_byte [MAP_ENTRIES_DEF];
  bit                entry_set  [MAP_ENTRIES_DEF];
  pmmu_result_t      pending [$];
  int                errors;

  function new();
    latch  = '0;
    errors = 0;
    foreach (entry_set[i]) entry_set[i] = 1'b0;
  endfunction

  function void note_access(logic [ADDR_W-1:0] addr, logic wr, logic sup,
                            logic [DATA_W-1:0] data);
    logic [MAP_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    entry;
    pmmu_result_t         res;
    idx        = {latch[CTX_W-1:0], sup, 1'b0, addr[ADDR_W-1:OFFSET_W]};
    entry      = entry_byte[idx];
    res.status = STAT_RAM;
    res.phys   = '0;
    res.berr   = 1'b0;
    if (!latch[LATCH_EN_BIT]) begin
      if (wr) begin
        entry_byte[idx] = data;
        entry_set[idx]  = 1'b1;
        res.status      = STAT_MAP_WRITTEN;
      end else begin
        res.status = STAT_READ_OFF;
      end
    end else if (!entry_set[idx]) begin
      res.status = STAT_INVALID;
    end else if (entry[ENTRY_BERR_BIT]) begin
      res.status = STAT_BUS_ERROR;
      res.berr   = 1'b1;
    end else if (entry[ENTRY_WP_BIT] && wr) begin
      res.status = STAT_WRITE_FAULT;
    end else begin
      res.phys = {entry[PAGE_W-1:0], addr[OFFSET_W-1:0]};
    end
    pending.push_back(res);
  endfunction

  function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] phys,
                             logic berr);
    pmmu_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result: status %0d phys %h berr %b",
               $time, status, phys, berr);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      errors++;
    end
    if (phys !== want.phys) begin
      $display("%0t: physical_address expected %h actual %h", $time, want.phys, phys);
      errors++;
    end
    if (berr !== want.berr) begin
      $display("%0t: bus_error expected %b actual %b", $time, want.berr, berr);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ROUNDS      = 8;
  localparam int unsigned MAP_WRITES  = 30;
  localparam int unsigned LOOKUPS     = 50;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  bit   press_go;
  bit   press_done;
  int unsigned cycles = 0;

  mmu_scoreboard sb;

  pmmu_req_if req ();
  pmmu_cfg_if cfg ();
  pmmu_rsp_if rsp ();

  paged_mmu_translate uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic access(input logic [ADDR_W-1:0] addr, input logic wr, input logic sup,
                        input logic [DATA_W-1:0] data);
    while (!calm && $urandom_range(0, 99) < 24) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.address    <= addr;
    req.write      <= wr;
    req.supervisor <= sup;
    req.write_data <= data;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    sb.note_access(addr, wr, sup, data);
  endtask

  task automatic set_latch(input logic [DATA_W-1:0] value);
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid         <= 1'b1;
    cfg.control_latch <= value;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    sb.latch = value;
  endtask

  // result side: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        sb.check_result(rsp.status, rsp.physical_address, rsp.bus_error);
      if (press_go && !press_done) begin
        stall_left = HOLD_CYCLES;
        press_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    logic [CTX_W-1:0]    ctx;
    logic [PAGE_W:0]     slots [$];
    logic [PAGE_W:0]     slot;
    logic [DATA_W-1:0]   data;
    sb = new();
    rst_ni            <= 1'b0;
    req.valid         <= 1'b0;
    req.address       <= '0;
    req.write         <= 1'b0;
    req.supervisor    <= 1'b0;
    req.write_data    <= '0;
    cfg.valid         <= 1'b0;
    cfg.control_latch <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_latch(8'h00);
    access(19'h7FFFF,          1'b0, 1'b1, 8'hFF);
    access(19'h00000,          1'b1, 1'b0, 8'h15);
    access(19'h7FFFF,          1'b1, 1'b0, 8'h3F);
    access({6'd1, 13'h0000},   1'b1, 1'b0, 8'h80);
    access({6'd2, 13'h1FFF},   1'b1, 1'b0, 8'h40);
    access({6'd3, 13'h0AAA},   1'b1, 1'b0, 8'hC0);
    access({6'd63, 13'h1555},  1'b1, 1'b1, 8'h00);
    access({6'd5, 13'h0000},   1'b1, 1'b1, 8'hFF);
    set_latch(8'h80);
    access({6'd0, 13'h1FFF},   1'b0, 1'b0, 8'h00);
    access(19'h7FFFF,          1'b1, 1'b0, 8'hFF);
    access({6'd1, 13'h0123},   1'b0, 1'b0, 8'h00);
    access({6'd1, 13'h1FFF},   1'b1, 1'b0, 8'h00);
    access({6'd2, 13'h0456},   1'b0, 1'b0, 8'h00);
    access({6'd2, 13'h0456},   1'b1, 1'b0, 8'h00);
    access({6'd3, 13'h1000},   1'b1, 1'b0, 8'h00);
    access({6'd63, 13'h1FFF},  1'b0, 1'b1, 8'h00);
    access({6'd5, 13'h0001},   1'b1, 1'b1, 8'h00);
    access({6'd4, 13'h0800},   1'b0, 1'b0, 8'h00);
    access({6'd0, 13'h0000},   1'b0, 1'b1, 8'h00);
    set_latch(8'h7F);
    access({6'd10, 13'h0F0F},  1'b1, 1'b1, 8'h2A);
    set_latch(8'hFF);
    access({6'd10, 13'h0F0F},  1'b1, 1'b1, 8'h00);
    access({6'd0, 13'h0000},   1'b0, 1'b0, 8'h00);

    for (int r = 0; r < ROUNDS; r++) begin
      if (r == 0)
        ctx = '0;
      else if (r == ROUNDS - 1)
        ctx = '1;
      else
        ctx = CTX_W'($urandom_range(0, 127));
      calm = (r == 3);
      set_latch({1'b0, ctx});
      slots.delete();
      repeat (MAP_WRITES) begin
        slot = (PAGE_W + 1)'($urandom);
        data = DATA_W'($urandom);
        if ($urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 99) < 50) data[7:6] = 2'b00;
          access({slot[PAGE_W-1:0], 13'($urandom)}, 1'b1, slot[PAGE_W], data);
          slots.push_back(slot);
        end else begin
          access({slot[PAGE_W-1:0], 13'($urandom)}, 1'b0, slot[PAGE_W], data);
        end
      end
      set_latch({1'b1, ctx});
      if (r == 2) press_go = 1'b1;
      repeat (LOOKUPS) begin
        if (slots.size() > 0 && $urandom_range(0, 99) < 80)
          slot = slots[$urandom_range(0, slots.size() - 1)];
        else
          slot = (PAGE_W + 1)'($urandom);
        access({slot[PAGE_W-1:0], 13'($urandom)}, 1'($urandom_range(0, 1)),
               slot[PAGE_W], DATA_W'($urandom));
      end
    end
    calm = 1'b0;

    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/pmmu_pkg.sv
hw/rtl/pmmu_if.sv
hw/rtl/pmmu_ram.sv
hw/rtl/pmmu_decode.sv
hw/rtl/paged_mmu_translate.sv
hw/rtl/pmmu_checker.sv
bench/tb.sv
